FILE: sv/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// shared sizes, types and sequencer states for the merge sort engine
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W     = $clog2(MAX_ITEMS);

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic [CNT_W-1:0]             cnt_t;
    typedef logic [ADDR_W-1:0]            addr_t;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PRIME,
        S_MERGE,
        S_OPRIME,
        S_OUT
    } state_t;

endpackage

FILE: sv/merge_sort_engine_unit.sv
// ----------------------------------------------------------------------------
// merge_sort_engine_unit
// collects a set of signed values, merge-sorts it bottom-up between two
// stores and streams the sorted set out, last one flagged
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  input    | in_valid / in_stall    | value, last_item
//  output   | out_valid / out_stall  | sorted_value, last_result, overflow
//  config   | cfg_wr_en              | cfg_wr_data (descending)
//
//  load writes each beat to store a; beats past MAX_ITEMS are dropped
//  sort of n values: ceil(log2 n) passes, each an S_PRIME step then n merge
//  steps of one compare and one store write a cycle through the single merge
//  unit, then S_OPRIME before the first result
//  results then leave in order, held while out_stall is high
//  in_stall is high from the last beat of a set until its last result leaves
//  reset clears the sequencer, counters and the order bit; stores are not
//  cleared, only written entries are ever read
// ----------------------------------------------------------------------------
module merge_sort_engine_unit
    import mse_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  data_t value,
    input  logic  last_item,
    output logic  out_valid,
    input  logic  out_stall,
    output data_t sorted_value,
    output logic  last_result,
    output logic  overflow,
    input  logic  cfg_wr_en,
    input  logic  cfg_wr_data
);

    data_t store_a [MAX_ITEMS];
    data_t store_b [MAX_ITEMS];

    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    logic   dropped_reg, dropped_next;
    logic   desc_reg;
    logic   sel_reg, sel_next;
    cnt_t   w_reg, w_next;
    cnt_t   i_reg, i_next;
    cnt_t   j_reg, j_next;
    cnt_t   mid_reg, mid_next;
    cnt_t   hi_reg, hi_next;
    cnt_t   k_reg, k_next;

    data_t  rda_i_reg, rda_j_reg, rdb_i_reg, rdb_j_reg;
    data_t  left_head, right_head;
    addr_t  rd_addr_i, rd_addr_j, wr_addr;
    data_t  wr_data;
    logic   we_a, we_b;

    logic   in_beat, out_beat;
    logic   take_left;
    logic   block_end, pass_end, sort_done;
    cnt_t   k_inc;
    cnt_t   blk_lo, blk_rem, blk_mid, blk_hi;
    logic [CNT_W:0] w_dbl;

    assign in_beat  = in_valid && !in_stall;
    assign out_beat = out_valid && !out_stall;

    assign left_head  = sel_reg ? rdb_i_reg : rda_i_reg;
    assign right_head = sel_reg ? rdb_j_reg : rda_j_reg;

    // model's merge: right side wins on ties
    always_comb
    begin
        if (j_reg >= hi_reg)
            take_left = 1'b1;
        else if (i_reg >= mid_reg)
            take_left = 1'b0;
        else if (desc_reg)
            take_left = left_head > right_head;
        else
            take_left = left_head < right_head;
    end

    assign k_inc     = k_reg + cnt_t'(1);
    assign w_dbl     = {w_reg, 1'b0};
    assign block_end = (k_inc == hi_reg);
    assign pass_end  = block_end && (hi_reg == count_reg);
    assign sort_done = (w_dbl >= {1'b0, count_reg});

    // bounds of the next pair of runs, clipped to the set size
    assign blk_lo  = (state_reg == S_PRIME) ? '0 : hi_reg;
    assign blk_rem = count_reg - blk_lo;
    assign blk_mid = blk_lo + ((w_reg >= blk_rem) ? blk_rem : w_reg);
    assign blk_hi  = blk_lo + ((w_dbl >= {1'b0, blk_rem}) ? blk_rem : w_dbl[CNT_W-1:0]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_beat && last_item)
                    state_next = S_PRIME;
            end
            S_PRIME:
            begin
                if (w_reg >= count_reg)
                    state_next = S_OPRIME;
                else
                    state_next = S_MERGE;
            end
            S_MERGE:
            begin
                if (pass_end)
                    state_next = sort_done ? S_OPRIME : S_PRIME;
            end
            S_OPRIME:
                state_next = S_OUT;
            S_OUT:
            begin
                if (out_beat && (k_inc == count_reg))
                    state_next = S_LOAD;
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        sel_next     = sel_reg;
        w_next       = w_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        k_next       = k_reg;
        we_a         = 1'b0;
        we_b         = 1'b0;
        wr_addr      = count_reg[ADDR_W-1:0];
        wr_data      = value;
        in_stall     = 1'b1;
        out_valid    = 1'b0;

        unique case (state_reg)
            S_LOAD:
            begin
                in_stall = 1'b0;
                if (in_beat)
                begin
                    if (count_reg < cnt_t'(MAX_ITEMS))
                    begin
                        we_a       = 1'b1;
                        count_next = count_reg + cnt_t'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (last_item)
                    begin
                        w_next   = cnt_t'(1);
                        sel_next = 1'b0;
                    end
                end
            end
            S_PRIME:
            begin
                i_next   = '0;
                j_next   = blk_mid;
                mid_next = blk_mid;
                hi_next  = blk_hi;
                k_next   = '0;
            end
            S_MERGE:
            begin
                wr_addr = k_reg[ADDR_W-1:0];
                wr_data = take_left ? left_head : right_head;
                we_a    = sel_reg;
                we_b    = !sel_reg;
                k_next  = k_inc;
                if (take_left)
                    i_next = i_reg + cnt_t'(1);
                else
                    j_next = j_reg + cnt_t'(1);
                if (pass_end)
                begin
                    sel_next = !sel_reg;
                    w_next   = w_dbl[CNT_W-1:0];
                end
                else if (block_end)
                begin
                    i_next   = hi_reg;
                    j_next   = blk_mid;
                    mid_next = blk_mid;
                    hi_next  = blk_hi;
                end
            end
            S_OPRIME:
            begin
                k_next = '0;
                i_next = '0;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_beat)
                begin
                    k_next = k_inc;
                    i_next = k_inc;
                    if (k_inc == count_reg)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                    end
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // reads follow the next pointers so the heads are registered together with the pointers
    assign rd_addr_i = i_next[ADDR_W-1:0];
    assign rd_addr_j = j_next[ADDR_W-1:0];

    assign sorted_value = left_head;
    assign last_result  = (k_inc == count_reg);
    assign overflow     = dropped_reg;

    always_ff @(posedge clk)
    begin
        if (we_a)
            store_a[wr_addr] <= wr_data;
        rda_i_reg <= store_a[rd_addr_i];
        rda_j_reg <= store_a[rd_addr_j];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
            store_b[wr_addr] <= wr_data;
        rdb_i_reg <= store_b[rd_addr_i];
        rdb_j_reg <= store_b[rd_addr_j];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            desc_reg    <= 1'b0;
            sel_reg     <= 1'b0;
            w_reg       <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            mid_reg     <= '0;
            hi_reg      <= '0;
            k_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            sel_reg     <= sel_next;
            w_reg       <= w_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            mid_reg     <= mid_next;
            hi_reg      <= hi_next;
            k_reg       <= k_next;
            if (cfg_wr_en)
                desc_reg <= cfg_wr_data;
        end
    end

endmodule

FILE: verif/merge_sort_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// merge_sort_engine_unit_tb
// loads sets of signed values into the sort engine under both orders,
// predicts each sorted run in a scoreboard and checks every output beat
// field by field; random pacing on both channels, a long output hold-off,
// full and overflowing sets
// ----------------------------------------------------------------------------
module merge_sort_engine_unit_tb
    import mse_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit    ORDER_ASC      = 1'b0;
    localparam bit    ORDER_DESC     = 1'b1;
    localparam data_t VAL_MAX        = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t VAL_MIN        = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam int    LONG_HOLD      = 300;
    localparam int    SETTLE_CYCLES  = 20;
    localparam int    WATCHDOG_LIMIT = 4000;
    localparam int    PHASE_ITEMS    = 2;

    typedef struct {
        data_t value;
        logic  last;
        logic  ovf;
    } sorted_beat_t;

    class sort_scoreboard;
        bit           descending;
        data_t        held[$];
        bit           dropped;
        sorted_beat_t expected_q[$];
        int           errors;

        function bit precedes(data_t a, data_t b);
            return descending ? (a > b) : (a < b);
        endfunction

        // keeps a beat unless full; a last beat closes the set, queues its sorted run
        function void note_input(data_t v, logic is_last);
            data_t ordered[$];
            int    j;
            if (held.size() < MAX_ITEMS)
                held.push_back(v);
            else
                dropped = 1'b1;
            if (!is_last)
                return;
            foreach (held[i])
            begin
                j = 0;
                while (j < ordered.size() && !precedes(held[i], ordered[j]))
                    j++;
                ordered.insert(j, held[i]);
            end
            foreach (ordered[k])
                expected_q.push_back('{ordered[k], k == ordered.size() - 1, dropped});
            held.delete();
            dropped = 1'b0;
        endfunction

        function void report(string field, logic [DATA_WIDTH-1:0] exp_v,
                             logic [DATA_WIDTH-1:0] act_v);
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp_v, act_v);
        endfunction

        function void check(data_t v, logic l, logic o);
            sorted_beat_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat, expected none actual %0h last %b ovf %b",
                         $time, v, l, o);
                return;
            end
            e = expected_q.pop_front();
            if (v !== e.value)
                report("sorted_value", e.value, v);
            if (l !== e.last)
                report("last_result", e.last, l);
            if (o !== e.ovf)
                report("overflow", e.ovf, o);
        endfunction
    endclass

    logic  clk         = 1'b0;
    logic  rst_n       = 1'b0;
    logic  in_valid    = 1'b0;
    data_t value       = '0;
    logic  last_item   = 1'b0;
    logic  out_stall   = 1'b0;
    logic  cfg_wr_en   = 1'b0;
    logic  cfg_wr_data = 1'b0;
    logic  in_stall;
    logic  out_valid;
    data_t sorted_value;
    logic  last_result;
    logic  overflow;

    sort_scoreboard sb = new();

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit calm        = 1'b0;
    bit hold_req    = 1'b0;
    int quiet_cycles = 0;

    merge_sort_engine_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .last_item   (last_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sorted_value(sorted_value),
        .last_result (last_result),
        .overflow    (overflow),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // output side pacing, including the one long hold-off
    initial
    begin : rx_pacing
        int left;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                if (hold_req)
                begin
                    left     = LONG_HOLD;
                    hold_req = 1'b0;
                end
                else if (!calm && $urandom_range(99) < rx_idle_pct)
                    left = $urandom_range(12, 1);
            end
            if (left != 0)
            begin
                out_stall <= 1'b1;
                left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check(sorted_value, last_result, overflow);
    end

    always @(posedge clk)
    begin
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            quiet_cycles = 0;
        else if (rst_n)
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic data_t pick_value();
        case ($urandom_range(3))
            0: return data_t'($urandom);
            1: return data_t'(int'($urandom_range(8)) - 4);
            2:
            begin
                case ($urandom_range(3))
                    0:       return VAL_MAX;
                    1:       return VAL_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: return data_t'($urandom) >>> 20;
        endcase
    endfunction

    task automatic send_item(data_t v, logic is_last);
        int gap;
        gap = (!calm && $urandom_range(99) < tx_idle_pct) ? $urandom_range(12, 1) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        value     <= v;
        last_item <= is_last;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(v, is_last);
    endtask

    task automatic send_list(data_t vals[$]);
        foreach (vals[k])
            send_item(vals[k], k == vals.size() - 1);
    endtask

    // random set: random, constant or rising content, fresh pacing per set
    task automatic random_set(int n);
        data_t vals[$];
        data_t base;
        int    mode;
        mode = $urandom_range(3);
        base = pick_value();
        tx_idle_pct = $urandom_range(2) * 20;
        rx_idle_pct = $urandom_range(2) * 20;
        for (int k = 0; k < n; k++)
        begin
            case (mode)
                1:       vals.push_back(base);
                2:       vals.push_back(base + data_t'(k));
                default: vals.push_back(pick_value());
            endcase
        end
        send_list(vals);
    endtask

    // sender pauses until the last expected beat has left
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_order(bit order);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= order;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.descending = order;
        @(posedge clk);
    endtask

    task automatic small_sets(int budget);
        int n;
        while (budget > 0)
        begin
            n = $urandom_range(6, 1);
            random_set(n);
            budget -= n;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: single value, extremes with a repeated minimum or maximum, repeats
        write_order(ORDER_ASC);
        send_list('{VAL_MAX});
        send_list('{VAL_MAX, VAL_MIN, '0, '1, data_t'(1), VAL_MIN, data_t'(-2)});
        write_order(ORDER_DESC);
        send_list('{VAL_MIN, data_t'(1), VAL_MAX, '1, '0, VAL_MAX, data_t'(-2)});
        send_list('{data_t'(3), data_t'(3), data_t'(-2), data_t'(3), data_t'(-2)});

        for (int phase = 2; phase < 6; phase++)
        begin
            write_order(phase[0] ? ORDER_DESC : ORDER_ASC);
            if (phase == 5)
                calm = 1'b1;
            if (phase == 4)
            begin
                hold_req = 1'b1;
                random_set(4);
                random_set(5);
                random_set(3);
                drain();
            end
            small_sets(PHASE_ITEMS / 2);
            if (phase == 2)
                random_set(MAX_ITEMS);
            if (phase == 3)
                random_set(MAX_ITEMS + 2);
            small_sets(PHASE_ITEMS / 2);
        end

        drain();
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
